@@ hw/rtl/mpr_pkg.sv @@
// Shared types, widths and codes of the masking pan resolver.
package mpr_pkg;

	localparam int CENT_W  = 20;
	localparam int PAN_W   = 16;
	localparam int LIMIT_W = 15;
	localparam int COEFF_W = 16;
	localparam int GROUP_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd2;

	localparam logic [CENT_W-1:0]  TOLERANCE_RST = 20'd3200;
	localparam logic [LIMIT_W-1:0] PAN_LIMIT_RST = 15'd16384;
	localparam logic [COEFF_W-1:0] SMOOTHING_RST = 16'd0;

	// One group: both centroids and both pans.
	typedef struct packed {
		logic [CENT_W-1:0]        c0;
		logic [CENT_W-1:0]        c1;
		logic signed [PAN_W-1:0]  p0;
		logic signed [PAN_W-1:0]  p1;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MERGE,
		ST_DIST,
		ST_START,
		ST_MAG,
		ST_TARGET,
		ST_SMOOTH,
		ST_WRITE
	} state_t;

	// Start and completion of a serial unit.
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

@@ hw/rtl/masking_pan_resolver.sv @@
// Top level of the masking pan resolver: group table, sequencer and result register.
//
// Usage: each input transaction (func, group_index, slot_index, centroid) on the
// in_valid / in_stall channel yields exactly one result transaction carrying
// pan_zero and pan_one of the addressed group on out_valid / out_stall.
// func update writes the slot's centroid and steps that slot's pan toward its
// masking target; func clear empties the group. A group beyond NUM_GROUPS is
// left alone and returns two zero pans.
// Path, accept to result: a clear or an out-of-range group goes straight
// to write; an update passes read, merge, dist and start, then mag (only with
// masking), target, smooth and write. The next accept can follow once write has
// handed its result over. The serial units carry most of an update:
// 15 multiply plus 15 divide bit steps for the pan magnitude, then 16
// bit steps of the one-pole multiply. One transaction is in work at a time;
// in_stall is high from accept until the result enters the output register.
// The result register holds while out_stall is high, and the next transaction
// may be accepted and worked on meanwhile; it waits at its end for the slot.
// Reset clears the group valid bits, so every group reads as all zero; the
// configuration registers return to tolerance 3200, pan_limit 16384 and
// smoothing_coeff 0. Write configuration only while no transaction is open.
module masking_pan_resolver #(
	parameter int NUM_GROUPS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mpr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mpr_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   func,
	input  logic [mpr_pkg::GROUP_W-1:0]            group_index,
	input  logic                                   slot_index,
	input  logic [mpr_pkg::CENT_W-1:0]             centroid,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mpr_pkg::PAN_W-1:0]       pan_zero,
	output logic signed [mpr_pkg::PAN_W-1:0]       pan_one
);

	localparam int CW = mpr_pkg::CENT_W;
	localparam int PW = mpr_pkg::PAN_W;
	localparam int LW = mpr_pkg::LIMIT_W;
	localparam int KW = mpr_pkg::COEFF_W;
	localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	mpr_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [CW-1:0] tolerance_q;
	logic [LW-1:0] pan_limit_q;
	logic [KW-1:0] coeff_q;

	// Group table: one row per group, valid bit per row.
	mpr_pkg::row_t           mem [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]   valid_q;
	mpr_pkg::row_t           row_q;
	logic                    rvalid_q;

	// Transaction under work.
	logic [mpr_pkg::GROUP_W-1:0] group_q;
	logic                        slot_q;
	logic [CW-1:0]               cent_q;
	logic                        upd_q;
	logic                        clr_q;
	mpr_pkg::row_t               work_q;
	logic [CW-1:0]               absd_q;
	logic                        le_q;
	logic                        masked_q;

	// Result register.
	logic                  out_valid_q;
	logic signed [PW-1:0]  pan_zero_q;
	logic signed [PW-1:0]  pan_one_q;

	logic [AW-1:0]  addr;
	logic           accept;
	logic           in_range;
	logic           out_free;
	mpr_pkg::row_t  eff_row;
	mpr_pkg::row_t  merged;
	logic [CW:0]    d01;
	logic [CW:0]    d10;
	logic [CW:0]    tol_diff;
	logic           masked;
	logic [LW-1:0]  mag;
	logic [LW-1:0]  mag_eff;
	logic           neg;
	logic signed [PW:0]   mag_x;
	logic signed [PW:0]   old_x;
	logic signed [PW:0]   target_x;
	logic signed [PW:0]   err_x;
	logic signed [PW-1:0] new_pan;

	mpr_pkg::unit_req_t mag_req, sm_req;
	mpr_pkg::unit_rsp_t mag_rsp, sm_rsp;

	// Outputs of the sequencer.
	logic st_read, st_merge, st_dist, st_start, st_target, st_write;

	assign addr     = AW'(group_q);
	assign accept   = in_valid && !in_stall;
	assign in_range = 32'(group_index) < NUM_GROUPS;
	assign out_free = !out_valid_q || !out_stall;

	// Datapath combinational terms.
	always_comb begin
		eff_row = rvalid_q ? row_q : '0;
		merged  = eff_row;
		if (slot_q) begin
			merged.c1 = cent_q;
		end else begin
			merged.c0 = cent_q;
		end
		d01      = {1'b0, work_q.c0} - {1'b0, work_q.c1};
		d10      = {1'b0, work_q.c1} - {1'b0, work_q.c0};
		tol_diff = {1'b0, tolerance_q} - {1'b0, absd_q};
		masked   = !tol_diff[CW] && (tol_diff[CW-1:0] != '0);
		mag_eff  = masked_q ? mag : '0;
		// Lower centroid goes left: slot 0 negative when c0 <= c1.
		neg      = le_q ^ slot_q;
		mag_x    = $signed({2'b00, mag_eff});
		old_x    = slot_q ? (PW + 1)'(work_q.p1) : (PW + 1)'(work_q.p0);
		target_x = neg ? -mag_x : mag_x;
		err_x    = neg ? old_x + mag_x : old_x - mag_x;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpr_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!in_range || func == mpr_pkg::FUNC_CLEAR) begin
						state_d = mpr_pkg::ST_WRITE;
					end else begin
						state_d = mpr_pkg::ST_READ;
					end
				end
			end
			mpr_pkg::ST_READ:   state_d = mpr_pkg::ST_MERGE;
			mpr_pkg::ST_MERGE:  state_d = mpr_pkg::ST_DIST;
			mpr_pkg::ST_DIST:   state_d = mpr_pkg::ST_START;
			mpr_pkg::ST_START:  state_d = masked ? mpr_pkg::ST_MAG : mpr_pkg::ST_TARGET;
			mpr_pkg::ST_MAG: begin
				if (mag_rsp.done) begin
					state_d = mpr_pkg::ST_TARGET;
				end
			end
			mpr_pkg::ST_TARGET: state_d = mpr_pkg::ST_SMOOTH;
			mpr_pkg::ST_SMOOTH: begin
				if (sm_rsp.done) begin
					state_d = mpr_pkg::ST_WRITE;
				end
			end
			mpr_pkg::ST_WRITE: begin
				if (out_free) begin
					state_d = mpr_pkg::ST_IDLE;
				end
			end
			default: state_d = mpr_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall      = (state_q != mpr_pkg::ST_IDLE);
		st_read       = (state_q == mpr_pkg::ST_READ);
		st_merge      = (state_q == mpr_pkg::ST_MERGE);
		st_dist       = (state_q == mpr_pkg::ST_DIST);
		st_start      = (state_q == mpr_pkg::ST_START);
		st_target     = (state_q == mpr_pkg::ST_TARGET);
		st_write      = (state_q == mpr_pkg::ST_WRITE);
		mag_req.start = st_start && masked;
		sm_req.start  = st_target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= mpr_pkg::TOLERANCE_RST;
			pan_limit_q <= mpr_pkg::PAN_LIMIT_RST;
			coeff_q     <= mpr_pkg::SMOOTHING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mpr_pkg::REG_TOLERANCE: tolerance_q <= cfg_data[CW-1:0];
				mpr_pkg::REG_PAN_LIMIT: pan_limit_q <= cfg_data[LW-1:0];
				mpr_pkg::REG_SMOOTHING: coeff_q     <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	// Table memory: registered read, single write port.
	always_ff @(posedge clk) begin
		if (st_read) begin
			row_q <= mem[addr];
		end
		if (st_write && upd_q) begin
			mem[addr] <= work_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (st_read) begin
				rvalid_q <= valid_q[addr];
			end
			if (st_write && upd_q) begin
				valid_q[addr] <= 1'b1;
			end else if (st_write && clr_q) begin
				valid_q[addr] <= 1'b0;
			end
		end
	end

	// Transaction payload; zero row stands for clear and out-of-range results.
	always_ff @(posedge clk) begin
		if (accept) begin
			group_q <= group_index;
			slot_q  <= slot_index;
			cent_q  <= centroid;
			work_q  <= '0;
		end else if (st_merge) begin
			work_q <= merged;
		end else if (sm_rsp.done) begin
			if (slot_q) begin
				work_q.p1 <= new_pan;
			end else begin
				work_q.p0 <= new_pan;
			end
		end
		if (st_dist) begin
			absd_q <= d01[CW] ? d10[CW-1:0] : d01[CW-1:0];
			le_q   <= d01[CW] || (d01 == '0);
		end
		if (st_start) begin
			masked_q <= masked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 1'b0;
			clr_q <= 1'b0;
		end else if (accept) begin
			upd_q <= in_range && (func == mpr_pkg::FUNC_UPDATE);
			clr_q <= in_range && (func == mpr_pkg::FUNC_CLEAR);
		end
	end

	// Result register: load at the end of a transaction, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_write && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_write && out_free) begin
			pan_zero_q <= work_q.p0;
			pan_one_q  <= work_q.p1;
		end
	end

	mpr_magnitude u_magnitude (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mag_req),
		.rsp       (mag_rsp),
		.diff      (tol_diff[CW-1:0]),
		.pan_limit (pan_limit_q),
		.tolerance (tolerance_q),
		.mag       (mag)
	);

	mpr_smooth u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sm_req),
		.rsp    (sm_rsp),
		.err    (err_x),
		.target (target_x[PW-1:0]),
		.coeff  (coeff_q),
		.pan    (new_pan)
	);

	assign out_valid = out_valid_q;
	assign pan_zero  = pan_zero_q;
	assign pan_one   = pan_one_q;

endmodule

@@ hw/rtl/mpr_magnitude.sv @@
// Bit-serial multiply and divide: floor(pan_limit * diff / tolerance).
module mpr_magnitude (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mpr_pkg::unit_req_t                 req,
	output mpr_pkg::unit_rsp_t                 rsp,
	input  logic [mpr_pkg::CENT_W-1:0]         diff,
	input  logic [mpr_pkg::LIMIT_W-1:0]        pan_limit,
	input  logic [mpr_pkg::CENT_W-1:0]         tolerance,
	output logic [mpr_pkg::LIMIT_W-1:0]        mag
);

	localparam int LW    = mpr_pkg::LIMIT_W;
	localparam int CW    = mpr_pkg::CENT_W;
	localparam int ACC_W = CW + LW + 1;
	localparam int CNT_W = $clog2(LW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(LW - 1);

	logic [ACC_W-1:0] acc_q;
	logic [CW-1:0]    diff_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             div_q;
	logic             done_q;

	logic [CW:0]      mul_sum;
	logic [CW:0]      div_try;
	logic [CW:0]      div_sub;
	logic             div_bit;

	always_comb begin
		mul_sum = acc_q[ACC_W-1:LW] + (acc_q[0] ? {1'b0, diff_q} : '0);
		div_try = {acc_q[ACC_W-2:LW], acc_q[LW-1]};
		div_sub = div_try - {1'b0, tolerance};
		div_bit = !div_sub[CW];
	end

	// Shift right while multiplying, shift left while dividing.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= {(CW + 1)'(0), pan_limit};
			diff_q <= diff;
		end else if (busy_q) begin
			if (!div_q) begin
				acc_q <= {1'b0, mul_sum, acc_q[LW-1:1]};
			end else begin
				acc_q <= {1'b0, (div_bit ? div_sub[CW-1:0] : div_try[CW-1:0]),
					acc_q[LW-2:0], div_bit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					cnt_q <= '0;
					if (div_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						div_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign mag      = acc_q[LW-1:0];

endmodule

@@ hw/rtl/mpr_smooth.sv @@
// Bit-serial one-pole step: target + round(coeff * (old - target) / 2^16).
module mpr_smooth (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpr_pkg::unit_req_t                  req,
	output mpr_pkg::unit_rsp_t                  rsp,
	input  logic signed [mpr_pkg::PAN_W:0]      err,
	input  logic signed [mpr_pkg::PAN_W-1:0]    target,
	input  logic [mpr_pkg::COEFF_W-1:0]         coeff,
	output logic signed [mpr_pkg::PAN_W-1:0]    pan
);

	localparam int PW    = mpr_pkg::PAN_W;
	localparam int KW    = mpr_pkg::COEFF_W;
	localparam int HI_W  = PW + 2;
	localparam int ACC_W = HI_W + KW;
	localparam int CNT_W = $clog2(KW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(KW - 1);

	logic [ACC_W-1:0]       acc_q;
	logic signed [PW:0]     err_q;
	logic signed [PW-1:0]   target_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic signed [HI_W-1:0] sum;
	logic signed [HI_W-1:0] quot;
	logic signed [HI_W-1:0] total;

	always_comb begin
		sum   = $signed(acc_q[ACC_W-1:KW]) + (acc_q[0] ? HI_W'(err_q) : '0);
		// Round to nearest, ties up: add the bit just below the point.
		quot  = $signed(acc_q[ACC_W-1:KW]) + $signed({(HI_W - 1)'(0), acc_q[KW-1]});
		total = quot + HI_W'(target_q);
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= {HI_W'(0), coeff};
			err_q    <= err;
			target_q <= target;
		end else if (busy_q) begin
			acc_q <= {sum[HI_W-1], sum, acc_q[KW-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign pan      = total[PW-1:0];

endmodule
